>>> design/spm_pkg.sv
// Shared types and constants for the sparse polynomial multiply unit.
// Used by spm_cell, spm_term_gen and the top level; depends on nothing else.
package spm_pkg;

  localparam int COEF_IN_W = 16;   // loaded coefficient width
  localparam int EXP_IN_W  = 10;   // loaded exponent width
  localparam int PROD_W    = 32;   // coefficient pair product width
  localparam int COEF_W    = 38;   // accumulated coefficient width
  localparam int PEXP_W    = 11;   // product exponent width

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_MUL    = 2'd2
  } action_t;

  // Product term travelling down the cell chain.
  typedef struct packed {
    logic              vld;
    logic [PEXP_W-1:0] exp;
    logic [COEF_W-1:0] coef;
  } token_t;

  // Result term held in one cell.
  typedef struct packed {
    logic              occ;
    logic [PEXP_W-1:0] exp;
    logic [COEF_W-1:0] coef;
  } entry_t;

  // Status from the term generator to the control.
  typedef struct packed {
    logic busy;       // pairs still being issued or multiplied
    logic empty;      // an operand has no terms
    logic load_drop;  // a load hit a full operand this cycle
  } gen_stat_t;

endpackage

>>> design/sparse_polynomial_multiply_unit.sv
// Sparse polynomial multiply unit. A multiply issues one term pair per cycle,
// then waits for the last product to pass the cell chain, then emits one result
// term per cycle while out_tready is high. The chain length sets the drain time.
// Reset (synchronous, rst_n low) empties the operands, the chain and the flag.
module sparse_polynomial_multiply_unit
  import spm_pkg::*;
#(
  parameter int MAX_TERMS       = 8,
  parameter int RESULT_CAPACITY = 64,
  parameter int EXP_BITS        = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // coefficient[15:0], exponent[25:16]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // product_coefficient[37:0],
                                  // product_exponent[48:38], overflow[49]
  output logic        out_tuser,  // term_valid
  output logic        out_tlast   // last_term
);

  localparam int EW = (EXP_BITS < EXP_IN_W) ? EXP_BITS : EXP_IN_W;
  localparam int DW = (RESULT_CAPACITY > 1) ? $clog2(RESULT_CAPACITY) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t    state_r, state_nxt;
  logic      dropped_r, dropped_nxt;
  logic [DW-1:0] drain_r, drain_nxt;

  logic      in_xfer, out_xfer, load_a, load_b, start, clear, last;
  gen_stat_t stat;
  token_t    tok_w [RESULT_CAPACITY+1];
  entry_t    ent_w [RESULT_CAPACITY+1];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign last      = !ent_w[0].occ || !ent_w[1].occ;
  assign clear     = out_xfer && last;

  always_comb begin
    load_a = 1'b0;
    load_b = 1'b0;
    start  = 1'b0;
    if (in_xfer) begin
      unique case (action_t'(in_tuser))
        ACT_LOAD_A: load_a = 1'b1;
        ACT_LOAD_B: load_b = 1'b1;
        ACT_MUL:    start  = !stat.empty;
        default: ;
      endcase
    end
  end

  spm_term_gen #(
    .MAX_TERMS (MAX_TERMS),
    .EW        (EW)
  ) u_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_a_i (load_a),
    .load_b_i (load_b),
    .coef_i   (in_tdata[COEF_IN_W-1:0]),
    .exp_i    (in_tdata[COEF_IN_W +: EW]),
    .start_i  (start),
    .clear_i  (clear),
    .tok_o    (tok_w[0]),
    .stat_o   (stat)
  );

  assign ent_w[RESULT_CAPACITY] = '0;

  for (genvar k = 0; k < RESULT_CAPACITY; k++) begin : g_cell
    spm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_i (out_xfer),
      .tok_i   (tok_w[k]),
      .next_i  (ent_w[k+1]),
      .tok_o   (tok_w[k+1]),
      .ent_o   (ent_w[k])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    drain_nxt   = drain_r;
    // a token falling off the chain end had no room
    dropped_nxt = dropped_r | stat.load_drop | tok_w[RESULT_CAPACITY].vld;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (action_t'(in_tuser) == ACT_MUL)) begin
          state_nxt = stat.empty ? ST_EMIT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stat.busy) begin
          state_nxt = ST_DRAIN;
          drain_nxt = DW'(RESULT_CAPACITY - 1);
        end
      end
      ST_DRAIN: begin
        if (drain_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          drain_nxt = drain_r - DW'(1);
        end
      end
      ST_EMIT: begin
        if (clear) begin
          state_nxt   = ST_IDLE;
          dropped_nxt = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      dropped_r <= 1'b0;
      drain_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
      drain_r   <= drain_nxt;
    end
  end

  // Head cell is the output register; an empty chain gives the empty product.
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tuser  = ent_w[0].occ;
  assign out_tlast  = last;
  assign out_tdata  = {6'd0, dropped_r,
                       ent_w[0].occ ? ent_w[0].exp  : {PEXP_W{1'b0}},
                       ent_w[0].occ ? ent_w[0].coef : {COEF_W{1'b0}}};

endmodule

>>> design/spm_cell.sv
// One cell of the result chain: holds one result term and merges or
// forwards the product token from its upstream neighbor. Depends on spm_pkg.
module spm_cell
  import spm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift_i,   // emit: take the downstream neighbor's entry
  input  token_t tok_i,
  input  entry_t next_i,
  output token_t tok_o,
  output entry_t ent_o
);

  entry_t ent_r, ent_nxt;
  token_t tok_r, tok_nxt;

  always_comb begin
    ent_nxt = ent_r;
    tok_nxt = tok_i;
    tok_nxt.vld = 1'b0;
    if (shift_i) begin
      ent_nxt = next_i;
    end else if (tok_i.vld) begin
      if (ent_r.occ && (ent_r.exp == tok_i.exp)) begin
        ent_nxt.coef = ent_r.coef + tok_i.coef;
      end else if (!ent_r.occ) begin
        ent_nxt.occ  = 1'b1;
        ent_nxt.exp  = tok_i.exp;
        ent_nxt.coef = tok_i.coef;
      end else begin
        // occupied by another exponent: pass downstream
        tok_nxt.vld = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.occ <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;
  assign ent_o = ent_r;

endmodule

>>> design/spm_term_gen.sv
// Operand term stores, pair sequencer and coefficient multiplier.
// Feeds one product token per cycle into the cell chain. Depends on spm_pkg.
module spm_term_gen
  import spm_pkg::*;
#(
  parameter int MAX_TERMS = 8,
  parameter int EW        = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_a_i,
  input  logic                 load_b_i,
  input  logic [COEF_IN_W-1:0] coef_i,
  input  logic [EW-1:0]        exp_i,
  input  logic                 start_i,
  input  logic                 clear_i,
  output token_t               tok_o,
  output gen_stat_t            stat_o
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  logic [COEF_IN_W-1:0] a_coef_r [MAX_TERMS];
  logic [EW-1:0]        a_exp_r  [MAX_TERMS];
  logic [COEF_IN_W-1:0] b_coef_r [MAX_TERMS];
  logic [EW-1:0]        b_exp_r  [MAX_TERMS];
  logic [CW-1:0]        a_cnt_r, b_cnt_r;
  logic [IW-1:0]        i_r, j_r;
  logic                 run_r;

  logic                 s1_vld_r;
  logic [COEF_IN_W-1:0] s1_ca_r, s1_cb_r;
  logic [EW:0]          s1_ex_r;
  token_t               tok_r;

  logic                 a_full, b_full, j_end, i_end;
  logic signed [PROD_W-1:0] prod;

  assign a_full = (a_cnt_r == CW'(MAX_TERMS));
  assign b_full = (b_cnt_r == CW'(MAX_TERMS));
  assign j_end  = (CW'(j_r) == b_cnt_r - CW'(1));
  assign i_end  = (CW'(i_r) == a_cnt_r - CW'(1));
  assign prod   = $signed(s1_ca_r) * $signed(s1_cb_r);

  // Operand stores and stage-1 operand registers: payload only, no reset.
  always_ff @(posedge clk) begin
    if (load_a_i && !a_full) begin
      a_coef_r[a_cnt_r[IW-1:0]] <= coef_i;
      a_exp_r[a_cnt_r[IW-1:0]]  <= exp_i;
    end
    if (load_b_i && !b_full) begin
      b_coef_r[b_cnt_r[IW-1:0]] <= coef_i;
      b_exp_r[b_cnt_r[IW-1:0]]  <= exp_i;
    end
    s1_ca_r  <= a_coef_r[i_r];
    s1_cb_r  <= b_coef_r[j_r];
    s1_ex_r  <= {1'b0, a_exp_r[i_r]} + {1'b0, b_exp_r[j_r]};
  end

  // Counts, pair sequencer (first operand outer) and the token register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r   <= '0;
      b_cnt_r   <= '0;
      run_r     <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      s1_vld_r  <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      s1_vld_r   <= run_r;
      tok_r.vld  <= s1_vld_r;
      tok_r.exp  <= PEXP_W'(s1_ex_r);
      tok_r.coef <= {{(COEF_W - PROD_W){prod[PROD_W-1]}}, prod};
      if (clear_i) begin
        a_cnt_r <= '0;
        b_cnt_r <= '0;
      end else begin
        if (load_a_i && !a_full) a_cnt_r <= a_cnt_r + CW'(1);
        if (load_b_i && !b_full) b_cnt_r <= b_cnt_r + CW'(1);
      end
      if (start_i) begin
        run_r <= 1'b1;
        i_r   <= '0;
        j_r   <= '0;
      end else if (run_r) begin
        if (j_end) begin
          j_r <= '0;
          if (i_end) begin
            run_r <= 1'b0;
          end else begin
            i_r <= i_r + IW'(1);
          end
        end else begin
          j_r <= j_r + IW'(1);
        end
      end
    end
  end

  assign tok_o            = tok_r;
  assign stat_o.busy      = run_r | s1_vld_r | tok_r.vld;
  assign stat_o.empty     = (a_cnt_r == '0) || (b_cnt_r == '0);
  assign stat_o.load_drop = (load_a_i && a_full) || (load_b_i && b_full);

endmodule
